// File: src/cpr_pkg.sv
package cpr_pkg;

  localparam int FramesDefault   = 8;
  localparam int PageBitsDefault = 16;

  // Widths fixed by the interface
  localparam int CfgW      = 4;
  localparam int FrameIdxW = 3;

  localparam logic [CfgW-1:0] FramesInUseReset = 4'd3;

  typedef enum logic [1:0] {
    StIdle,
    StLookup,
    StSweep
  } state_e;

  // Broadcast controls from the sequencer to every cell
  typedef struct packed {
    logic seed;   // load the hand token from seed_i
    logic sweep;  // token cell acts: pass over or take the page
  } cell_ctl_t;

endpackage

// File: src/cpr_cell.sv
module cpr_cell #(
  parameter int PAGE_BITS = cpr_pkg::PageBitsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cpr_pkg::cell_ctl_t    ctl_i,
  input  logic [PAGE_BITS-1:0]  page_i,
  input  logic                  active_i,
  input  logic                  seed_i,
  input  logic                  token_i,
  input  logic                  hit_set_i,
  output logic                  match_o,
  output logic                  pass_o,
  output logic                  victim_o,
  output logic                  valid_o,
  output logic [PAGE_BITS-1:0]  page_o
);
  import cpr_pkg::*;

  logic                 valid_q;
  logic                 use_q;
  logic                 token_q, token_d;
  logic [PAGE_BITS-1:0] page_q;
  logic                 pass;

  // Token holder with the use bit set gives its second chance away
  assign pass     = token_q & valid_q & use_q;
  assign pass_o   = pass;
  assign victim_o = token_q & ~pass;
  assign match_o  = active_i & valid_q & (page_q == page_i);
  assign valid_o  = valid_q;
  assign page_o   = page_q;

  // On a sweep step the token moves on; a single-frame ring hands it back to itself
  always_comb begin
    token_d = token_q;
    if (ctl_i.seed) begin
      token_d = seed_i;
    end
    if (ctl_i.sweep) begin
      token_d = token_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      use_q   <= 1'b0;
      token_q <= 1'b0;
    end else begin
      token_q <= token_d;
      if (hit_set_i) begin
        use_q <= 1'b1;
      end else if (ctl_i.sweep && token_q) begin
        if (pass) begin
          use_q <= 1'b0;
        end else begin
          valid_q <= 1'b1;
          use_q   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.sweep && victim_o) begin
      page_q <= page_i;
    end
  end

endmodule

// File: src/clock_page_replacement.sv
// Clock (second-chance) page replacement over a row of frame cells. One request
// is taken at a time: a lookup checks every active frame for a hit, and a hit
// result is registered, then the sequencer returns to idle to accept the next
// request. A miss seeds the hand token and sweeps, clearing the use bit of each
// frame it passes over, until a victim is found; its result is then registered.
// The hand token steps one cell per clock around the ring of active frames, and
// both a hit and a victim wait until the output register is free before the
// result is written and the sequencer goes back to idle.
// The next request is accepted while a result still waits in the output register.
// frames_in_use of 0 acts as 1 and values above FRAMES act as FRAMES.
module clock_page_replacement #(
  parameter int FRAMES    = cpr_pkg::FramesDefault,
  parameter int PAGE_BITS = cpr_pkg::PageBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [cpr_pkg::CfgW-1:0]      cfg_frames_in_use_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [PAGE_BITS-1:0]          page_number_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          page_fault_o,
  output logic [cpr_pkg::FrameIdxW-1:0] frame_index_o,
  output logic                          evicted_valid_o,
  output logic [PAGE_BITS-1:0]          evicted_page_o
);
  import cpr_pkg::*;

  localparam int IdxW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CntW = $clog2(FRAMES + 1);
  localparam int NW   = (CntW > CfgW) ? CntW : CfgW;
  localparam int XW   = (IdxW > FrameIdxW) ? IdxW : FrameIdxW;

  state_e state_q, state_d;

  logic [CfgW-1:0]      frames_in_use_q;
  logic [IdxW-1:0]      hand_q, hand_d;
  logic [PAGE_BITS-1:0] page_q;

  logic                 out_valid_q, out_valid_d;
  logic                 fault_q, fault_d;
  logic [IdxW-1:0]      idx_q, idx_d;
  logic                 ev_valid_q, ev_valid_d;
  logic [PAGE_BITS-1:0] ev_page_q, ev_page_d;

  logic [NW-1:0]        n_act;
  logic [NW-1:0]        cfg_ext;
  logic [IdxW-1:0]      start_hand;
  logic [IdxW-1:0]      hit_idx;
  logic [IdxW-1:0]      vic_idx;
  logic [PAGE_BITS-1:0] vic_page;
  logic                 vic_valid;
  logic                 out_free;
  logic                 hit_commit;
  logic [XW-1:0]        idx_ext;

  logic [FRAMES-1:0]    active, last, seed, token_in, hit_set;
  logic [FRAMES-1:0]    match, pass, victim, cvalid, hit_oh;
  logic [PAGE_BITS-1:0] cpage [FRAMES];
  cell_ctl_t            ctl;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_in_use_q <= FramesInUseReset;
    end else if (cfg_valid_i) begin
      frames_in_use_q <= cfg_frames_in_use_i;
    end
  end

  // Active frame count, clamped into 1..FRAMES
  always_comb begin
    cfg_ext = NW'(frames_in_use_q);
    if (cfg_ext == '0) begin
      n_act = NW'(1);
    end else if (cfg_ext > NW'(FRAMES)) begin
      n_act = NW'(FRAMES);
    end else begin
      n_act = cfg_ext;
    end
  end

  assign start_hand = (NW'(hand_q) >= n_act) ? '0 : hand_q;

  for (genvar i = 0; i < FRAMES; i++) begin : g_cell
    assign active[i] = NW'(i) < n_act;
    assign last[i]   = NW'(i) == (n_act - NW'(1));
    assign seed[i]   = start_hand == IdxW'(i);
    if (i == 0) begin : g_wrap
      assign token_in[i] = |(pass & last);
    end else begin : g_link
      assign token_in[i] = pass[i-1] & ~last[i-1];
    end

    cpr_cell #(
      .PAGE_BITS(PAGE_BITS)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (ctl),
      .page_i   (page_q),
      .active_i (active[i]),
      .seed_i   (seed[i]),
      .token_i  (token_in[i]),
      .hit_set_i(hit_set[i]),
      .match_o  (match[i]),
      .pass_o   (pass[i]),
      .victim_o (victim[i]),
      .valid_o  (cvalid[i]),
      .page_o   (cpage[i])
    );
  end

  // Lowest matching frame wins
  assign hit_oh = match & (~match + FRAMES'(1));

  always_comb begin
    hit_idx   = '0;
    vic_idx   = '0;
    vic_page  = '0;
    vic_valid = 1'b0;
    for (int i = 0; i < FRAMES; i++) begin
      if (hit_oh[i]) begin
        hit_idx = hit_idx | IdxW'(i);
      end
      if (victim[i]) begin
        vic_idx   = vic_idx | IdxW'(i);
        vic_valid = vic_valid | cvalid[i];
        if (cvalid[i]) begin
          vic_page = vic_page | cpage[i];
        end
      end
    end
  end

  assign out_free   = !out_valid_q || out_ready_i;
  assign hit_commit = (state_q == StLookup) && (|match) && out_free;
  assign hit_set    = hit_oh & {FRAMES{hit_commit}};

  always_comb begin
    state_d     = state_q;
    hand_d      = hand_q;
    out_valid_d = out_valid_q && !out_ready_i;
    fault_d     = fault_q;
    idx_d       = idx_q;
    ev_valid_d  = ev_valid_q;
    ev_page_d   = ev_page_q;
    ctl         = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = StLookup;
        end
      end
      StLookup: begin
        if (|match) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            fault_d     = 1'b0;
            idx_d       = hit_idx;
            ev_valid_d  = 1'b0;
            ev_page_d   = '0;
            state_d     = StIdle;
          end
        end else begin
          ctl.seed = 1'b1;
          state_d  = StSweep;
        end
      end
      StSweep: begin
        if (|victim) begin
          if (out_free) begin
            ctl.sweep   = 1'b1;
            out_valid_d = 1'b1;
            fault_d     = 1'b1;
            idx_d       = vic_idx;
            ev_valid_d  = vic_valid;
            ev_page_d   = vic_page;
            hand_d      = (NW'(vic_idx) == (n_act - NW'(1))) ? '0 : vic_idx + IdxW'(1);
            state_d     = StIdle;
          end
        end else begin
          ctl.sweep = 1'b1;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      hand_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hand_q      <= hand_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      page_q <= page_number_i;
    end
    fault_q    <= fault_d;
    idx_q      <= idx_d;
    ev_valid_q <= ev_valid_d;
    ev_page_q  <= ev_page_d;
  end

  assign idx_ext         = XW'(idx_q);
  assign in_ready_o      = state_q == StIdle;
  assign out_valid_o     = out_valid_q;
  assign page_fault_o    = fault_q;
  assign frame_index_o   = idx_ext[FrameIdxW-1:0];
  assign evicted_valid_o = ev_valid_q;
  assign evicted_page_o  = ev_page_q;

endmodule

// File: src/cpr_checker.sv
module cpr_checker #(
  parameter int PAGE_BITS = cpr_pkg::PageBitsDefault
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic                          page_fault_o,
  input logic [cpr_pkg::FrameIdxW-1:0] frame_index_o,
  input logic                          evicted_valid_o,
  input logic [PAGE_BITS-1:0]          evicted_page_o
);
  import cpr_pkg::*;

  // One request in flight: acceptance closes the input side
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while another is in flight");

  // Only a fault can displace a page
  a_evict_needs_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && evicted_valid_o |-> page_fault_o)
    else $error("eviction reported without a fault");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before it was taken");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(frame_index_o) && $stable(evicted_page_o)
      && $stable(page_fault_o) && $stable(evicted_valid_o))
    else $error("stalled result changed");

endmodule

bind clock_page_replacement cpr_checker #(
  .PAGE_BITS(PAGE_BITS)
) u_cpr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .page_fault_o   (page_fault_o),
  .frame_index_o  (frame_index_o),
  .evicted_valid_o(evicted_valid_o),
  .evicted_page_o (evicted_page_o)
);
